### rtl/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg
// Types, codes and helpers shared by the assembler token lexer modules.
// ----------------------------------------------------------------------------
package atl_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_RESULTS     = 4;

    localparam logic [2:0] K_BYTE      = 3'd0;
    localparam logic [2:0] K_TOKEN_END = 3'd1;
    localparam logic [2:0] K_LINE_END  = 3'd2;
    localparam logic [2:0] K_DONE      = 3'd3;
    localparam logic [2:0] K_ERROR     = 3'd4;

    localparam logic [1:0] E_UNCLOSED  = 2'd0;
    localparam logic [1:0] E_ESCAPE    = 2'd1;
    localparam logic [1:0] E_HEX       = 2'd2;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_source;
    } t_source;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic [1:0] error_code;
        logic       last;
    } t_result;

    // All results caused by one source byte, oldest in slot 0
    typedef struct packed {
        logic [2:0]                   count;
        t_result [MAX_RESULTS-1:0]    res;
    } t_bundle;

    // Append one result; extra results beyond the bundle size are dropped
    function automatic t_bundle f_put(t_bundle b, logic [2:0] kind, logic [7:0] value,
                                      logic [1:0] err);
        t_bundle r;
        r = b;
        if (b.count < 3'(MAX_RESULTS)) begin
            r.res[b.count[1:0]] = '{kind: kind, value: value, error_code: err, last: 1'b0};
            r.count = b.count + 3'd1;
        end
        return r;
    endfunction

endpackage

### rtl/atl_front.sv
// ----------------------------------------------------------------------------
// atl_front
// Classifies each source byte, updates the lexer state and builds the bundle
// of results that the byte causes.
// ----------------------------------------------------------------------------
module atl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  atl_pkg::t_source  i_item,
    output logic              o_push,
    output atl_pkg::t_bundle  o_bundle
);
    import atl_pkg::*;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_COMMENT,
        MODE_STRING,
        MODE_ESCAPE,
        MODE_HEX,
        MODE_FAILED
    } t_mode;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    t_mode       r_mode, n_mode;
    logic        r_quote_dbl, n_quote_dbl;
    logic        r_token_open, n_token_open;
    logic        r_line_tok, n_line_tok;
    logic [11:0] r_hex_acc, n_hex_acc;
    logic [1:0]  r_hex_cnt, n_hex_cnt;

    logic [7:0]  b;
    logic [15:0] cp;
    logic        esc_ok;
    logic [7:0]  esc_val;
    logic        hex_ok;
    logic [3:0]  hex_dig;
    logic        failed_now;
    t_bundle     bun;

    always_comb begin
        esc_ok  = 1'b1;
        esc_val = 8'h00;
        case (b)
            8'h61:     esc_val = 8'h07;
            8'h62:     esc_val = 8'h08;
            8'h66:     esc_val = 8'h0C;
            8'h6E:     esc_val = 8'h0A;
            8'h72:     esc_val = 8'h0D;
            8'h74:     esc_val = 8'h09;
            8'h76:     esc_val = 8'h0B;
            CH_SQUOTE: esc_val = CH_SQUOTE;
            CH_DQUOTE: esc_val = CH_DQUOTE;
            CH_BSLASH: esc_val = CH_BSLASH;
            default:   esc_ok  = 1'b0;
        endcase
    end

    always_comb begin
        hex_ok  = 1'b1;
        hex_dig = 4'h0;
        if (b inside {[8'h30:8'h39]}) begin
            hex_dig = b[3:0];
        end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            hex_dig = b[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign b  = i_item.source_byte;
    assign cp = {r_hex_acc, hex_dig};

    always_comb begin
        bun          = '0;
        failed_now   = 1'b0;
        n_mode       = r_mode;
        n_quote_dbl  = r_quote_dbl;
        n_token_open = r_token_open;
        n_line_tok   = r_line_tok;
        n_hex_acc    = r_hex_acc;
        n_hex_cnt    = r_hex_cnt;

        case (r_mode)
            MODE_COMMENT: begin
                if (b == CH_LF) begin
                    if (n_token_open) bun = f_put(bun, K_TOKEN_END, 8'h00, 2'd0);
                    if (n_line_tok) bun = f_put(bun, K_LINE_END, 8'h00, 2'd0);
                    n_token_open = 1'b0;
                    n_line_tok   = 1'b0;
                    n_mode       = MODE_NORMAL;
                end
            end
            MODE_STRING: begin
                if (b == (r_quote_dbl ? CH_DQUOTE : CH_SQUOTE)) begin
                    if (n_token_open) bun = f_put(bun, K_TOKEN_END, 8'h00, 2'd0);
                    n_token_open = 1'b0;
                    n_mode       = MODE_NORMAL;
                end else if (b == CH_BSLASH) begin
                    n_mode = MODE_ESCAPE;
                end else begin
                    bun = f_put(bun, K_BYTE, b, 2'd0);
                end
            end
            MODE_ESCAPE: begin
                if (b == CH_U) begin
                    n_hex_acc = '0;
                    n_hex_cnt = '0;
                    n_mode    = MODE_HEX;
                end else if (esc_ok) begin
                    bun    = f_put(bun, K_BYTE, esc_val, 2'd0);
                    n_mode = MODE_STRING;
                end else begin
                    bun        = f_put(bun, K_ERROR, 8'h00, E_ESCAPE);
                    failed_now = 1'b1;
                end
            end
            MODE_HEX: begin
                if (!hex_ok) begin
                    bun        = f_put(bun, K_ERROR, 8'h00, E_HEX);
                    failed_now = 1'b1;
                end else if (r_hex_cnt == 2'd3) begin
                    // Fourth digit: encode the code point as UTF-8
                    if (cp[15:7] == '0) begin
                        bun = f_put(bun, K_BYTE, {1'b0, cp[6:0]}, 2'd0);
                    end else if (cp[15:11] == '0) begin
                        bun = f_put(bun, K_BYTE, {3'b110, cp[10:6]}, 2'd0);
                        bun = f_put(bun, K_BYTE, {2'b10, cp[5:0]}, 2'd0);
                    end else begin
                        bun = f_put(bun, K_BYTE, {4'b1110, cp[15:12]}, 2'd0);
                        bun = f_put(bun, K_BYTE, {2'b10, cp[11:6]}, 2'd0);
                        bun = f_put(bun, K_BYTE, {2'b10, cp[5:0]}, 2'd0);
                    end
                    n_hex_acc = '0;
                    n_hex_cnt = '0;
                    n_mode    = MODE_STRING;
                end else begin
                    n_hex_acc = {r_hex_acc[7:0], hex_dig};
                    n_hex_cnt = r_hex_cnt + 2'd1;
                end
            end
            MODE_FAILED: begin
            end
            default: begin
                if (b == CH_SEMI) begin
                    if (n_token_open) bun = f_put(bun, K_TOKEN_END, 8'h00, 2'd0);
                    n_token_open = 1'b0;
                    n_mode       = MODE_COMMENT;
                end else if (b == CH_LF) begin
                    if (n_token_open) bun = f_put(bun, K_TOKEN_END, 8'h00, 2'd0);
                    if (n_line_tok) bun = f_put(bun, K_LINE_END, 8'h00, 2'd0);
                    n_token_open = 1'b0;
                    n_line_tok   = 1'b0;
                end else if (b inside {8'h20, [8'h09:8'h0D]}) begin
                    if (n_token_open) bun = f_put(bun, K_TOKEN_END, 8'h00, 2'd0);
                    n_token_open = 1'b0;
                end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                    if (n_token_open) bun = f_put(bun, K_TOKEN_END, 8'h00, 2'd0);
                    bun          = f_put(bun, K_BYTE, b, 2'd0);
                    n_quote_dbl  = (b == CH_DQUOTE);
                    n_token_open = 1'b1;
                    n_line_tok   = 1'b1;
                    n_mode       = MODE_STRING;
                end else begin
                    bun          = f_put(bun, K_BYTE, b, 2'd0);
                    n_token_open = 1'b1;
                    n_line_tok   = 1'b1;
                end
            end
        endcase

        if (failed_now) begin
            bun.res[bun.count[1:0] - 2'd1].last = 1'b1;
            n_mode = MODE_FAILED;
        end else if (i_item.end_of_source && n_mode != MODE_FAILED) begin
            if (n_mode inside {MODE_STRING, MODE_ESCAPE, MODE_HEX}) begin
                bun = f_put(bun, K_ERROR, 8'h00, E_UNCLOSED);
            end else begin
                // Close whatever is open; an open comment ends like a newline
                if (n_token_open) bun = f_put(bun, K_TOKEN_END, 8'h00, 2'd0);
                if (n_line_tok) bun = f_put(bun, K_LINE_END, 8'h00, 2'd0);
                bun = f_put(bun, K_DONE, 8'h00, 2'd0);
            end
            bun.res[bun.count[1:0] - 2'd1].last = 1'b1;
        end

        if (i_item.end_of_source) begin
            n_mode       = MODE_NORMAL;
            n_quote_dbl  = 1'b0;
            n_token_open = 1'b0;
            n_line_tok   = 1'b0;
            n_hex_acc    = '0;
            n_hex_cnt    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NORMAL;
            r_quote_dbl  <= 1'b0;
            r_token_open <= 1'b0;
            r_line_tok   <= 1'b0;
            r_hex_acc    <= '0;
            r_hex_cnt    <= '0;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_quote_dbl  <= n_quote_dbl;
            r_token_open <= n_token_open;
            r_line_tok   <= n_line_tok;
            r_hex_acc    <= n_hex_acc;
            r_hex_cnt    <= n_hex_cnt;
        end
    end

    assign o_push   = i_accept && (bun.count != 3'd0);
    assign o_bundle = bun;

endmodule

### rtl/atl_queue.sv
// ----------------------------------------------------------------------------
// atl_queue
// Short queue of result bundles between the classifier and the serializer.
// ----------------------------------------------------------------------------
module atl_queue #(
    parameter int DEPTH = atl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  atl_pkg::t_bundle  i_data,
    output logic              o_full,
    output logic              o_valid,
    output atl_pkg::t_bundle  o_data,
    input  logic              i_pop
);
    import atl_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_bundle         r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

### rtl/atl_back.sv
// ----------------------------------------------------------------------------
// atl_back
// Walks the head bundle one result per cycle into the output register if free.
// ----------------------------------------------------------------------------
module atl_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  atl_pkg::t_bundle  i_data,
    output logic              o_pop,
    output logic              o_empty,
    output atl_pkg::t_result  o_result,
    input  logic              i_pop
);
    import atl_pkg::*;

    logic [1:0] r_idx;
    logic       r_out_valid;
    t_result    r_out;
    logic       load;
    logic       at_end;

    assign load   = i_valid && (!r_out_valid || i_pop);
    assign at_end = ({1'b0, r_idx} == i_data.count - 3'd1);
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= i_data.res[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

### rtl/assembler_token_lexer.sv
// Path: each result passes through the bundle queue and then the output register.
// Throughput: one source byte per cycle while each byte causes at most one result;
// the serializer delivers one result per cycle while the receiver pops; a byte with
// several results is a burst, which the classifier-to-serializer bundle queue absorbs.
// Reset: synchronous active-low i_rst_n clears lexer state, queue and output valid.
// ----------------------------------------------------------------------------
// assembler_token_lexer
// Splits assembly source bytes into token bytes, token and line ends, done and errors.
// ----------------------------------------------------------------------------
module assembler_token_lexer #(
    parameter int QUEUE_DEPTH = atl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  atl_pkg::t_source  i_item,
    output logic              empty,
    input  logic              pop,
    output atl_pkg::t_result  o_result
);
    import atl_pkg::*;

    logic    accept;
    logic    q_push, q_full, q_valid, q_pop;
    t_bundle f_bundle, q_data;

    assign full   = q_full;
    assign accept = push && !q_full;

    atl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (q_push),
        .o_bundle (f_bundle)
    );

    atl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_bundle),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    atl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_data   (q_data),
        .o_pop    (q_pop),
        .o_empty  (empty),
        .o_result (o_result),
        .i_pop    (pop)
    );

`ifndef SYNTHESIS
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.last) |-> (o_result.kind == K_DONE || o_result.kind == K_ERROR))
        else $error("last flag on a non-final result kind");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind == K_ERROR) |-> o_result.last)
        else $error("error result without last flag");

    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> empty)
        else $error("result shown right after reset");

    a_bundle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid |-> (q_data.count != 3'd0 && q_data.count <= 3'(MAX_RESULTS)))
        else $error("queued bundle has bad result count");
`endif

endmodule

### tb/token_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// token_checker
// Watches the source and result queues of the token lexer. It keeps its own
// copy of the lexer state, works out the results due for every source byte
// transfer, and compares each result transfer with the oldest one due.
// ----------------------------------------------------------------------------
module token_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  atl_pkg::t_source  i_item,
    input  logic              i_empty,
    input  logic              i_pop,
    input  atl_pkg::t_result  i_result,
    output int                o_mismatch_count,
    output int                o_results_due
);
    import atl_pkg::*;

    localparam logic [1:0] NO_ERROR   = 2'd0;

    typedef enum logic [2:0] {
        SCAN_NORMAL,
        SCAN_COMMENT,
        SCAN_STRING,
        SCAN_ESCAPE,
        SCAN_HEX,
        SCAN_FAILED
    } scan_mode_e;

    scan_mode_e  scan_mode      = SCAN_NORMAL;
    logic        in_dquote      = 1'b0;
    logic        token_open     = 1'b0;
    logic        line_has_token = 1'b0;
    logic [15:0] hex_acc        = '0;
    logic [1:0]  hex_count      = '0;

    t_result     step_res [MAX_RESULTS];
    int          step_n;
    t_result     results_due [$];
    t_result     want;
    int          mismatch_total = 0;

    task automatic note_mismatch(input string reason, input t_result got,
                                 input t_result exp_res);
        string got_s;
        string want_s;
        got_s  = $sformatf("kind=%0d value=%02h err=%0d last=%0d",
                           got.kind, got.value, got.error_code, got.last);
        want_s = $sformatf("kind=%0d value=%02h err=%0d last=%0d",
                           exp_res.kind, exp_res.value, exp_res.error_code, exp_res.last);
        $display("%0t lexer mismatch (%s): got %s, want %s", $time, reason, got_s, want_s);
        mismatch_total++;
    endtask

    task automatic reset_scan();
        scan_mode      = SCAN_NORMAL;
        in_dquote      = 1'b0;
        token_open     = 1'b0;
        line_has_token = 1'b0;
        hex_acc        = '0;
        hex_count      = '0;
    endtask

    task automatic queue_result(input logic [2:0] kind, input logic [7:0] value,
                                input logic [1:0] code);
        // drop anything past the bundle size, as the block does
        if (step_n < MAX_RESULTS) begin
            step_res[step_n] = '{kind: kind, value: value, error_code: code, last: 1'b0};
            step_n++;
        end
    endtask

    task automatic end_token();
        if (token_open)
            queue_result(K_TOKEN_END, 8'h00, NO_ERROR);
        token_open = 1'b0;
    endtask

    task automatic end_line();
        end_token();
        if (line_has_token)
            queue_result(K_LINE_END, 8'h00, NO_ERROR);
        line_has_token = 1'b0;
    endtask

    // Work out every result caused by one source byte transfer
    task automatic lex_source_byte(input t_source item);
        logic [7:0]  b;
        logic [8:0]  esc;
        logic        digit_ok;
        logic [3:0]  digit;
        logic [15:0] cp;
        logic        failed_now;
        int          k;

        b          = item.source_byte;
        step_n     = 0;
        failed_now = 1'b0;
        digit_ok   = 1'b0;
        digit      = '0;

        case (scan_mode)
            SCAN_COMMENT: begin
                if (b == 8'h0A) begin
                    end_line();
                    scan_mode = SCAN_NORMAL;
                end
            end
            SCAN_STRING: begin
                if (b == (in_dquote ? 8'h22 : 8'h27)) begin
                    end_token();
                    scan_mode = SCAN_NORMAL;
                end else if (b == 8'h5C) begin
                    scan_mode = SCAN_ESCAPE;
                end else begin
                    queue_result(K_BYTE, b, NO_ERROR);
                end
            end
            SCAN_ESCAPE: begin
                case (b)
                    "a":     esc = {1'b1, 8'h07};
                    "b":     esc = {1'b1, 8'h08};
                    "f":     esc = {1'b1, 8'h0C};
                    "n":     esc = {1'b1, 8'h0A};
                    "r":     esc = {1'b1, 8'h0D};
                    "t":     esc = {1'b1, 8'h09};
                    "v":     esc = {1'b1, 8'h0B};
                    8'h27:   esc = {1'b1, 8'h27};
                    8'h22:   esc = {1'b1, 8'h22};
                    8'h5C:   esc = {1'b1, 8'h5C};
                    default: esc = '0;
                endcase
                if (b == "u") begin
                    hex_acc   = '0;
                    hex_count = '0;
                    scan_mode = SCAN_HEX;
                end else if (esc[8]) begin
                    queue_result(K_BYTE, esc[7:0], NO_ERROR);
                    scan_mode = SCAN_STRING;
                end else begin
                    queue_result(K_ERROR, 8'h00, E_ESCAPE);
                    failed_now = 1'b1;
                end
            end
            SCAN_HEX: begin
                if (b >= "0" && b <= "9") begin
                    digit_ok = 1'b1;
                    digit    = 4'(b - "0");
                end else if (b >= "a" && b <= "f") begin
                    digit_ok = 1'b1;
                    digit    = 4'(b - "a" + 8'd10);
                end else if (b >= "A" && b <= "F") begin
                    digit_ok = 1'b1;
                    digit    = 4'(b - "A" + 8'd10);
                end
                if (!digit_ok) begin
                    queue_result(K_ERROR, 8'h00, E_HEX);
                    failed_now = 1'b1;
                end else begin
                    cp = {hex_acc[11:0], digit};
                    if (hex_count == 2'd3) begin
                        // encode the code point in UTF-8
                        if (cp < 16'h0080) begin
                            queue_result(K_BYTE, cp[7:0], NO_ERROR);
                        end else if (cp < 16'h0800) begin
                            queue_result(K_BYTE, {3'b110, cp[10:6]}, NO_ERROR);
                            queue_result(K_BYTE, {2'b10, cp[5:0]}, NO_ERROR);
                        end else begin
                            queue_result(K_BYTE, {4'b1110, cp[15:12]}, NO_ERROR);
                            queue_result(K_BYTE, {2'b10, cp[11:6]}, NO_ERROR);
                            queue_result(K_BYTE, {2'b10, cp[5:0]}, NO_ERROR);
                        end
                        hex_acc   = '0;
                        hex_count = '0;
                        scan_mode = SCAN_STRING;
                    end else begin
                        hex_acc   = cp;
                        hex_count = hex_count + 2'd1;
                    end
                end
            end
            SCAN_FAILED: begin
            end
            default: begin
                if (b == ";") begin
                    end_token();
                    scan_mode = SCAN_COMMENT;
                end else if (b == 8'h0A) begin
                    end_line();
                end else if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
                    end_token();
                end else if (b == 8'h22 || b == 8'h27) begin
                    end_token();
                    queue_result(K_BYTE, b, NO_ERROR);
                    in_dquote      = (b == 8'h22);
                    token_open     = 1'b1;
                    line_has_token = 1'b1;
                    scan_mode      = SCAN_STRING;
                end else begin
                    queue_result(K_BYTE, b, NO_ERROR);
                    token_open     = 1'b1;
                    line_has_token = 1'b1;
                end
            end
        endcase

        if (failed_now) begin
            step_res[step_n-1].last = 1'b1;
            scan_mode = SCAN_FAILED;
            if (item.end_of_source)
                reset_scan();
        end else if (item.end_of_source) begin
            // a source that already failed ends silently
            if (scan_mode != SCAN_FAILED) begin
                if (scan_mode inside {SCAN_STRING, SCAN_ESCAPE, SCAN_HEX}) begin
                    queue_result(K_ERROR, 8'h00, E_UNCLOSED);
                end else begin
                    end_line();
                    queue_result(K_DONE, 8'h00, NO_ERROR);
                end
                step_res[step_n-1].last = 1'b1;
            end
            reset_scan();
        end

        for (k = 0; k < step_n; k++)
            results_due.push_back(step_res[k]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_scan();
            results_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (results_due.size() == 0) begin
                    note_mismatch("nothing due", i_result, '0);
                end else begin
                    want = results_due.pop_front();
                    if (i_result.kind != want.kind || i_result.value != want.value ||
                        i_result.error_code != want.error_code ||
                        i_result.last != want.last)
                        note_mismatch("wrong field", i_result, want);
                end
            end
            if (i_push && !i_full)
                lex_source_byte(i_item);
        end
        o_mismatch_count <= mismatch_total;
        o_results_due    <= results_due.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Feeds the token lexer short assembly sources: a few hand-made ones first,
// then random lines of identifiers, quoted strings with escapes, comments and
// whitespace, with some broken tails and noise. The sender works in bursts and
// the receiver stalls on its own pattern; token_checker judges every result.
// ----------------------------------------------------------------------------
module tb;
    import atl_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_BYTES = 430;

    typedef enum logic [1:0] {
        POP_STEADY,
        POP_MOSTLY,
        POP_SPARSE,
        POP_SQUARE
    } pop_style_e;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push    = 1'b0;
    logic       full;
    t_source    i_item  = '0;
    logic       empty;
    logic       pop     = 1'b0;
    t_result    o_result;

    int         mismatch_count;
    int         results_due;

    logic [7:0] text [$];
    int         burst_left   = 1;
    int         live_bytes   = 0;
    int         ignored_tail = 0;
    logic [5:0] stall_phase  = '0;
    pop_style_e pop_style    = POP_STEADY;
    int         idle_cycles  = 0;

    const logic [7:0] simple_esc [10] = '{"a", "b", "f", "n", "r", "t", "v",
                                          8'h27, 8'h22, 8'h5C};
    const logic [7:0] blank_chars [5] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};

    assembler_token_lexer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    token_checker u_lex_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_item           (i_item),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_result         (o_result),
        .o_mismatch_count (mismatch_count),
        .o_results_due    (results_due)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: switch stall style whenever stall_phase wraps to zero
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 6'd1;
        if (stall_phase == 6'd0)
            pop_style <= pop_style_e'($urandom_range(0, 3));
        case (pop_style)
            POP_STEADY: pop <= 1'b1;
            POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
            POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
            default:    pop <= stall_phase[2];
        endcase
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] base;
        base = ($urandom_range(0, 1) != 0) ? "A" : "a";
        if (v < 4'd10)
            return "0" + 8'(v);
        return base + 8'(v) - 8'd10;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        push   <= 1'b1;
        i_item <= '{source_byte: b, end_of_source: eos};
        // wait for the edge that takes the transfer, judged on full before it
        @(posedge i_clk iff !full);
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // Transfer the whole source, marking its final byte
    task automatic send_text();
        int idx;
        for (idx = 0; idx < text.size(); idx++)
            send_byte(text[idx], idx == text.size() - 1);
    endtask

    task automatic add_space();
        repeat ($urandom_range(1, 2))
            text.push_back(blank_chars[$urandom_range(0, 4)]);
    endtask

    task automatic add_ident();
        logic [7:0] c;
        repeat ($urandom_range(1, 6)) begin
            do begin
                c = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(8'h80, 8'hFF))
                                                : 8'($urandom_range(8'h21, 8'h7E));
            end while (c == ";" || c == 8'h22 || c == 8'h27);
            text.push_back(c);
        end
    endtask

    task automatic add_hex_digits(input int count);
        repeat (count)
            text.push_back(hex_char(4'($urandom_range(0, 15))));
    endtask

    task automatic add_u_escape();
        logic [15:0] cp;
        case ($urandom_range(0, 2))
            0:       cp = 16'($urandom_range(0, 16'h007F));
            1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
            default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        text.push_back(8'h5C);
        text.push_back("u");
        repeat (4) begin
            text.push_back(hex_char(cp[15:12]));
            cp = cp << 4;
        end
    endtask

    task automatic add_string(input logic closed);
        logic [7:0] q;
        logic [7:0] c;
        q = ($urandom_range(0, 1) != 0) ? 8'h22 : 8'h27;
        text.push_back(q);
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 3))
                0, 1: begin
                    do c = 8'($urandom_range(0, 255));
                    while (c == q || c == 8'h5C);
                    text.push_back(c);
                end
                2: begin
                    text.push_back(8'h5C);
                    text.push_back(simple_esc[$urandom_range(0, 9)]);
                end
                default: add_u_escape();
            endcase
        end
        if (closed)
            text.push_back(q);
    endtask

    task automatic add_line();
        int         ntok;
        int         k;
        logic [7:0] c;
        ntok = $urandom_range(0, 3);
        for (k = 0; k < ntok; k++) begin
            if (k > 0 || $urandom_range(0, 1) != 0)
                add_space();
            if ($urandom_range(0, 2) == 0)
                add_string(1'b1);
            else
                add_ident();
        end
        if ($urandom_range(0, 3) == 0) begin
            text.push_back(";");
            repeat ($urandom_range(0, 6)) begin
                do c = 8'($urandom_range(0, 255));
                while (c == 8'h0A);
                text.push_back(c);
            end
        end
        text.push_back(8'h0A);
    endtask

    // Mostly well-formed lines; the tail may break the source on purpose
    task automatic build_source();
        logic [7:0] c;
        text.delete();
        ignored_tail = 0;
        repeat ($urandom_range(1, 3)) add_line();
        case ($urandom_range(0, 9))
            4: add_ident();
            5: begin
                add_string(1'b0);
                text.push_back(8'h5C);
                do c = 8'($urandom_range(0, 255));
                while (c == "u" || c inside {"a", "b", "f", "n", "r", "t", "v",
                                             8'h27, 8'h22, 8'h5C});
                text.push_back(c);
                ignored_tail = $urandom_range(0, 2);
            end
            6: begin
                add_string(1'b0);
                text.push_back(8'h5C);
                text.push_back("u");
                add_hex_digits($urandom_range(0, 3));
                do c = 8'($urandom_range(0, 255));
                while (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
                text.push_back(c);
                ignored_tail = $urandom_range(0, 2);
            end
            7: begin
                add_string(1'b0);
                case ($urandom_range(0, 2))
                    1: text.push_back(8'h5C);
                    2: begin
                        text.push_back(8'h5C);
                        text.push_back("u");
                        add_hex_digits($urandom_range(0, 3));
                    end
                    default: begin
                    end
                endcase
            end
            8: begin
                text.push_back(";");
                add_ident();
            end
            9: begin
                repeat ($urandom_range(1, 4))
                    text.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
            end
        endcase
        // bytes after an error are ignored by the lexer
        repeat (ignored_tail)
            text.push_back(8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // byte extremes, comment, line end, two-byte \u, unclosed string at the end
        text = '{8'h00, 8'hFF, ";", "z", 8'h0A, 8'h22, 8'h5C, "u", "0", "7", "F", "f", 8'h27};
        send_text();
        // unknown escape on the final byte
        text = '{8'h27, 8'h5C, "q"};
        send_text();
        // bad hex digit, then a byte ignored while failed
        text = '{8'h27, 8'h5C, "u", "G", "x"};
        send_text();
        // comment still open at the end
        text = '{"a", ";", "c"};
        send_text();
        // one byte that causes four results
        text = '{"b"};
        send_text();

        while (live_bytes < RANDOM_BYTES) begin
            build_source();
            send_text();
            live_bytes += text.size() - ignored_tail;
        end

        push <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
